### rtl/core/camera_path_record_playback_assert.svh
// Assertion macros for the camera path recorder
`ifndef CAMERA_PATH_RECORD_PLAYBACK_ASSERT_SVH
`define CAMERA_PATH_RECORD_PLAYBACK_ASSERT_SVH

`ifndef SYNTHESIS
`define CPRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPRP_ASSERT_IMP(lbl, ante, cons)
`define CPRP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/cprp_pkg.sv
`timescale 1ns / 1ps
package cprp_pkg;

  localparam int TRACK_DEPTH_DEF = 1024;

  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;
  localparam int LAM_W  = 17;
  localparam int FRAC_W = 16;

  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_Q_W   = 17;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int SQ_W   = 64;
  localparam int NRM_W  = 32;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_REC_TGL  = 2'd1;
  localparam logic [1:0] MODE_PLAY_TGL = 2'd2;

  typedef enum logic [1:0] {
    REC_IDLE,
    REC_ON,
    REC_PLAY
  } rec_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCHW,
    ST_PICK,
    ST_RD1,
    ST_LAM,
    ST_LAMW,
    ST_MUL,
    ST_SQ,
    ST_SQRT,
    ST_NRM,
    ST_NRMW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [TIME_W-1:0] t_ms;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [HEAD_W-1:0] head_x;
    logic signed [HEAD_W-1:0] head_y;
    logic signed [HEAD_W-1:0] head_z;
  } sample_t;

endpackage

### rtl/core/cprp_div.sv
`timescale 1ns / 1ps
`include "camera_path_record_playback_assert.svh"
module cprp_div import cprp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_Q_W-1:0]   nsh_r, nsh_nxt;
  logic [DIV_Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, nsh_r[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nsh_nxt  = nsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      nsh_nxt = num[DIV_Q_W-1:0];
      den_nxt = den;
      cnt_nxt = CNT_W'(DIV_Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      q_nxt    = {q_r[DIV_Q_W-2:0], ge};
      nsh_nxt  = {nsh_r[DIV_Q_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nsh_r <= nsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

  `CPRP_ASSERT_IMP(a_div_start_idle, start, cnt_r == '0)
  `CPRP_ASSERT_IMP(a_div_done_end, done_r, cnt_r == '0)
  `CPRP_ASSERT_NXT(a_div_start_load, start, cnt_r == CNT_W'(DIV_Q_W))

endmodule

### rtl/core/camera_path_record_playback.sv
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_mode, in_now_ms, in_cur_pos_*, in_cur_head_*
// out      out_valid / out_ready    out_view_*, out_is_recording, out_sample_dropped
// cfg      cfg_we                   cfg_wdata (blend_enable)
//
// Toggles, record ticks and idle ticks go from idle straight to the done state.
// Playback tick with S search steps (S <= ceil(log2(N+1)) for N stored samples)
// over the single-port track memory, then outputs a stored sample or blends two.
// Blending uses the 17-step divider up to four times (not for the heading when it
// is zero) and the 32-step square root.
// Synchronous active-low reset; the track memory is not cleared.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register until taken.
`timescale 1ns / 1ps
`include "camera_path_record_playback_assert.svh"
module camera_path_record_playback import cprp_pkg::*; #(
  parameter int TRACK_DEPTH = TRACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic [TIME_W-1:0]        in_now_ms,
  input  logic signed [POS_W-1:0]  in_cur_pos_x,
  input  logic signed [POS_W-1:0]  in_cur_pos_y,
  input  logic signed [POS_W-1:0]  in_cur_pos_z,
  input  logic signed [HEAD_W-1:0] in_cur_head_x,
  input  logic signed [HEAD_W-1:0] in_cur_head_y,
  input  logic signed [HEAD_W-1:0] in_cur_head_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_view_valid,
  output logic signed [POS_W-1:0]  out_view_pos_x,
  output logic signed [POS_W-1:0]  out_view_pos_y,
  output logic signed [POS_W-1:0]  out_view_pos_z,
  output logic signed [HEAD_W-1:0] out_view_head_x,
  output logic signed [HEAD_W-1:0] out_view_head_y,
  output logic signed [HEAD_W-1:0] out_view_head_z,
  output logic                     out_is_recording,
  output logic                     out_sample_dropped,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);

  localparam int AW = $clog2(TRACK_DEPTH);
  localparam int CW = $clog2(TRACK_DEPTH + 1);

  function automatic logic signed [MUL_W-1:0] smp_comp(sample_t s, logic [2:0] j);
    logic signed [MUL_W-1:0] v;
    case (j)
      3'd0:    v = {s.pos_x[POS_W-1], s.pos_x};
      3'd1:    v = {s.pos_y[POS_W-1], s.pos_y};
      3'd2:    v = {s.pos_z[POS_W-1], s.pos_z};
      3'd3:    v = {{(MUL_W-HEAD_W){s.head_x[HEAD_W-1]}}, s.head_x};
      3'd4:    v = {{(MUL_W-HEAD_W){s.head_y[HEAD_W-1]}}, s.head_y};
      3'd5:    v = {{(MUL_W-HEAD_W){s.head_z[HEAD_W-1]}}, s.head_z};
      default: v = '0;
    endcase
    return v;
  endfunction

  // track memory
  sample_t        mem_r [TRACK_DEPTH];
  sample_t        rd_q_r;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  sample_t        wr_data;

  state_t         state_r, state_nxt;
  rec_mode_t      rec_r, rec_nxt;
  logic           blend_r;
  logic [TIME_W-1:0] origin_r, origin_nxt;
  logic [TIME_W-1:0] last_t_r, last_t_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] date_r, date_nxt;
  logic [CW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, mid;
  logic [CW-1:0]  lo_m1, cnt_m1;
  sample_t        s0_r, s0_nxt, s1_r, s1_nxt;
  logic [LAM_W-1:0] lam_r, lam_nxt, lam_c;
  logic [3:0]     k_r, k_nxt, pk;
  logic [1:0]     c_r, c_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt, prod_r, prod_nxt, sum, rnd;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  h_r [3];
  logic signed [MUL_W-1:0]  h_nxt [3];
  logic [SQ_W-1:0] n2_r, n2_nxt, sx_r, sx_nxt, sr_r, sr_nxt, sb_r, sb_nxt;
  logic [SQ_W:0]   sq_trial;
  logic [NRM_W-1:0] n_r, n_nxt;
  logic [NRM_W-1:0] mag;

  // staged result
  logic           rv_r, rv_nxt, rrec_r, rrec_nxt, rdrop_r, rdrop_nxt;
  logic signed [POS_W-1:0]  rp_r [3];
  logic signed [POS_W-1:0]  rp_nxt [3];
  logic signed [HEAD_W-1:0] rh_r [3];
  logic signed [HEAD_W-1:0] rh_nxt [3];

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic           ov_r, orec_r, odrop_r;
  logic signed [POS_W-1:0]  op_r [3];
  logic signed [HEAD_W-1:0] oh_r [3];
  logic           out_load;

  // divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quo;

  logic                 accept;
  logic [TIME_W-1:0]    date_in, den_t;
  logic                 store_ok, full;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign date_in  = in_now_ms - origin_r;
  assign store_ok = (cnt_r == '0) || (date_in > last_t_r);
  assign full     = (cnt_r >= CW'(TRACK_DEPTH));
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1    = lo_r - 1'b1;
  assign cnt_m1   = cnt_r - 1'b1;
  assign lam_c    = LAM_W'(17'h10000) - lam_r;
  assign den_t    = rd_q_r.t_ms - s0_r.t_ms;
  assign pk       = k_r - 1'b1;
  assign sum      = acc_r + prod_r;
  assign rnd      = sum + PROD_W'(32768);
  assign sq_trial = {1'b0, sr_r} + {1'b0, sb_r};
  assign mag      = h_r[c_r][MUL_W-1] ? NRM_W'(-h_r[c_r]) : NRM_W'(h_r[c_r]);
  assign prod_nxt = mul_a * mul_b;

  assign wr_en   = accept && (in_mode == MODE_TICK) && (rec_r == REC_ON) && store_ok && !full;
  assign wr_data = '{t_ms: date_in, pos_x: in_cur_pos_x, pos_y: in_cur_pos_y,
                     pos_z: in_cur_pos_z, head_x: in_cur_head_x, head_y: in_cur_head_y,
                     head_z: in_cur_head_z};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[cnt_r[AW-1:0]] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        mul_a = k_r[0] ? $signed({16'b0, lam_c}) : $signed({16'b0, lam_r});
        mul_b = smp_comp(k_r[0] ? s0_r : s1_r, k_r[3:1]);
      end
      ST_SQ: begin
        if (k_r[1:0] != 2'd3) begin
          mul_a = h_r[k_r[1:0]];
          mul_b = h_r[k_r[1:0]];
        end
      end
      default: ;
    endcase
  end

  cprp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_TICK && rec_r == REC_PLAY && cnt_r != '0) begin
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_SRCHW;
        end else if (lo_r >= cnt_r || lo_r == '0 || !blend_r) begin
          state_nxt = ST_PICK;
        end else begin
          state_nxt = ST_RD1;
        end
      end
      ST_SRCHW: state_nxt = ST_SRCH;
      ST_PICK:  state_nxt = ST_DONE;
      ST_RD1:   state_nxt = ST_LAM;
      ST_LAM:   state_nxt = (den_t == '0) ? ST_MUL : ST_LAMW;
      ST_LAMW:  state_nxt = div_done ? ST_MUL : ST_LAMW;
      ST_MUL:   state_nxt = (k_r == 4'd12) ? ST_SQ : ST_MUL;
      ST_SQ:    state_nxt = (k_r == 4'd3) ? ST_SQRT : ST_SQ;
      ST_SQRT:  state_nxt = (sb_r == '0) ? ST_NRM : ST_SQRT;
      ST_NRM: begin
        if (c_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else if (n_r != '0) begin
          state_nxt = ST_NRMW;
        end
      end
      ST_NRMW:  state_nxt = div_done ? ST_NRM : ST_NRMW;
      ST_DONE:  state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    rec_nxt    = rec_r;
    origin_nxt = origin_r;
    last_t_nxt = last_t_r;
    cnt_nxt    = cnt_r;
    date_nxt   = date_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    lam_nxt    = lam_r;
    k_nxt      = k_r;
    c_nxt      = c_r;
    acc_nxt    = acc_r;
    h_nxt      = h_r;
    n2_nxt     = n2_r;
    sx_nxt     = sx_r;
    sr_nxt     = sr_r;
    sb_nxt     = sb_r;
    n_nxt      = n_r;
    rv_nxt     = rv_r;
    rrec_nxt   = rrec_r;
    rdrop_nxt  = rdrop_r;
    rp_nxt     = rp_r;
    rh_nxt     = rh_r;
    rd_addr    = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rv_nxt    = 1'b0;
          rdrop_nxt = 1'b0;
          for (int i = 0; i < 3; i++) begin
            rp_nxt[i] = '0;
            rh_nxt[i] = '0;
          end
          case (in_mode)
            MODE_REC_TGL: begin
              if (rec_r == REC_ON) begin
                rec_nxt = REC_IDLE;
              end else begin
                rec_nxt    = REC_ON;
                origin_nxt = in_now_ms;
                cnt_nxt    = '0;
              end
            end
            MODE_PLAY_TGL: begin
              if (rec_r == REC_PLAY) begin
                rec_nxt = REC_IDLE;
              end else begin
                rec_nxt    = REC_PLAY;
                origin_nxt = in_now_ms;
              end
            end
            MODE_TICK: begin
              if (rec_r == REC_ON && store_ok) begin
                if (full) begin
                  rdrop_nxt = 1'b1;
                end else begin
                  cnt_nxt    = cnt_r + 1'b1;
                  last_t_nxt = date_in;
                end
              end else if (rec_r == REC_PLAY) begin
                if (cnt_r == '0) begin
                  rec_nxt = REC_IDLE;
                end else begin
                  date_nxt = date_in;
                  lo_nxt   = '0;
                  hi_nxt   = cnt_r;
                end
              end
            end
            default: ;
          endcase
          rrec_nxt = (rec_nxt == REC_ON);
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid;
          rd_addr = mid[AW-1:0];
        end else if (lo_r >= cnt_r) begin
          rd_addr = cnt_m1[AW-1:0];
          rec_nxt = REC_IDLE;
        end else if (lo_r == '0) begin
          rd_addr = '0;
        end else begin
          rd_addr = lo_m1[AW-1:0];
        end
      end
      ST_SRCHW: begin
        if (rd_q_r.t_ms < date_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_PICK: begin
        rv_nxt    = 1'b1;
        rp_nxt[0] = rd_q_r.pos_x;
        rp_nxt[1] = rd_q_r.pos_y;
        rp_nxt[2] = rd_q_r.pos_z;
        rh_nxt[0] = rd_q_r.head_x;
        rh_nxt[1] = rd_q_r.head_y;
        rh_nxt[2] = rd_q_r.head_z;
      end
      ST_RD1: begin
        s0_nxt  = rd_q_r;
        rd_addr = lo_r[AW-1:0];
      end
      ST_LAM: begin
        s1_nxt  = rd_q_r;
        k_nxt   = '0;
        lam_nxt = '0;
        if (den_t != '0) begin
          div_start = 1'b1;
          div_num   = {date_r - s0_r.t_ms, 16'b0};
          div_den   = DIV_DEN_W'(den_t);
        end
      end
      ST_LAMW: begin
        if (div_done) begin
          lam_nxt = div_quo;
        end
      end
      ST_MUL: begin
        if (k_r != '0) begin
          if (!pk[0]) begin
            acc_nxt = prod_r;
          end else begin
            case (pk[3:1])
              3'd0:    rp_nxt[0] = rnd[FRAC_W+POS_W-1:FRAC_W];
              3'd1:    rp_nxt[1] = rnd[FRAC_W+POS_W-1:FRAC_W];
              3'd2:    rp_nxt[2] = rnd[FRAC_W+POS_W-1:FRAC_W];
              3'd3:    h_nxt[0]  = sum[MUL_W-1:0];
              3'd4:    h_nxt[1]  = sum[MUL_W-1:0];
              3'd5:    h_nxt[2]  = sum[MUL_W-1:0];
              default: ;
            endcase
          end
        end
        k_nxt = (k_r == 4'd12) ? 4'd0 : k_r + 1'b1;
      end
      ST_SQ: begin
        if (k_r == 4'd1) begin
          n2_nxt = prod_r[SQ_W-1:0];
        end else if (k_r != '0) begin
          n2_nxt = n2_r + prod_r[SQ_W-1:0];
        end
        if (k_r == 4'd3) begin
          sx_nxt = n2_r + prod_r[SQ_W-1:0];
          sr_nxt = '0;
          sb_nxt = SQ_W'(1) << 62;
        end
        k_nxt = k_r + 1'b1;
      end
      ST_SQRT: begin
        if (sb_r == '0) begin
          n_nxt = sr_r[NRM_W-1:0];
          c_nxt = '0;
        end else begin
          if ({1'b0, sx_r} >= sq_trial) begin
            sx_nxt = sx_r - sq_trial[SQ_W-1:0];
            sr_nxt = (sr_r >> 1) + sb_r;
          end else begin
            sr_nxt = sr_r >> 1;
          end
          sb_nxt = sb_r >> 2;
        end
      end
      ST_NRM: begin
        if (c_r == 2'd3) begin
          rv_nxt = 1'b1;
        end else if (n_r == '0) begin
          rh_nxt[c_r] = '0;
          c_nxt       = c_r + 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'({mag, 15'b0}) + DIV_NUM_W'(n_r);
          div_den   = DIV_DEN_W'({n_r, 1'b0});
        end
      end
      ST_NRMW: begin
        if (div_done) begin
          rh_nxt[c_r] = h_r[c_r][MUL_W-1] ? -$signed(div_quo[HEAD_W-1:0])
                                           : $signed(div_quo[HEAD_W-1:0]);
          c_nxt       = c_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rec_r       <= REC_IDLE;
      blend_r     <= 1'b1;
      origin_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_r       <= rec_nxt;
      origin_r    <= origin_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        blend_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_t_r <= last_t_nxt;
    date_r   <= date_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    s0_r     <= s0_nxt;
    s1_r     <= s1_nxt;
    lam_r    <= lam_nxt;
    k_r      <= k_nxt;
    c_r      <= c_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    h_r      <= h_nxt;
    n2_r     <= n2_nxt;
    sx_r     <= sx_nxt;
    sr_r     <= sr_nxt;
    sb_r     <= sb_nxt;
    n_r      <= n_nxt;
    rv_r     <= rv_nxt;
    rrec_r   <= rrec_nxt;
    rdrop_r  <= rdrop_nxt;
    rp_r     <= rp_nxt;
    rh_r     <= rh_nxt;
    if (out_load) begin
      ov_r    <= rv_r;
      orec_r  <= rrec_r;
      odrop_r <= rdrop_r;
      op_r    <= rp_r;
      oh_r    <= rh_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_view_valid     = ov_r;
  assign out_view_pos_x     = op_r[0];
  assign out_view_pos_y     = op_r[1];
  assign out_view_pos_z     = op_r[2];
  assign out_view_head_x    = oh_r[0];
  assign out_view_head_y    = oh_r[1];
  assign out_view_head_z    = oh_r[2];
  assign out_is_recording   = orec_r;
  assign out_sample_dropped = odrop_r;

  `CPRP_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CW'(TRACK_DEPTH))
  `CPRP_ASSERT_NXT(a_accept_busy, accept, state_r != ST_IDLE)
  `CPRP_ASSERT_IMP(a_div_done_wait, div_done, state_r == ST_LAMW || state_r == ST_NRMW)
  `CPRP_ASSERT_IMP(a_srch_play, state_r == ST_SRCH, rec_r == REC_PLAY)

endmodule

### verif/tb_camera_path_record_playback.sv
`timescale 1ns / 1ps
module tb_camera_path_record_playback import cprp_pkg::*; ();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DEPTH = TRACK_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]               mode;
    logic [TIME_W-1:0]        now;
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [HEAD_W-1:0] hx, hy, hz;
  } tick_t;

  typedef struct {
    logic                     vv;
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [HEAD_W-1:0] hx, hy, hz;
    logic                     rec;
    logic                     drop;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic signed [POS_W-1:0] in_cur_pos_x = '0, in_cur_pos_y = '0, in_cur_pos_z = '0;
  logic signed [HEAD_W-1:0] in_cur_head_x = '0, in_cur_head_y = '0, in_cur_head_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_view_valid;
  logic signed [POS_W-1:0] out_view_pos_x, out_view_pos_y, out_view_pos_z;
  logic signed [HEAD_W-1:0] out_view_head_x, out_view_head_y, out_view_head_z;
  logic out_is_recording, out_sample_dropped;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  camera_path_record_playback dut (.*);

  always #5 clk = ~clk;

  // predictor state
  rec_mode_t         pb_mode = REC_IDLE;
  logic [TIME_W-1:0] pb_origin = '0;
  int                trk_n = 0;
  logic              blend_on = 1'b1;
  logic [TIME_W-1:0] trk_time [DEPTH];
  logic signed [POS_W-1:0]  trk_px [DEPTH], trk_py [DEPTH], trk_pz [DEPTH];
  logic signed [HEAD_W-1:0] trk_hx [DEPTH], trk_hy [DEPTH], trk_hz [DEPTH];

  pose_t poses_due [$];
  int n_items = 0, n_poses = 0, n_drops = 0, n_errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic pose_t sample_pose(int i);
    pose_t p;
    p = '{default: '0};
    p.vv = 1'b1;
    p.px = trk_px[i]; p.py = trk_py[i]; p.pz = trk_pz[i];
    p.hx = trk_hx[i]; p.hy = trk_hy[i]; p.hz = trk_hz[i];
    return p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] mix_pos(longint p0, longint p1, longint lam);
    longint s;
    s = lam * p1 + (65536 - lam) * p0 + 32768 + (longint'(1) << 48);
    return POS_W'(longint'(longint'(unsigned'(s) >> 16) - (longint'(1) << 32)));
  endfunction

  function automatic logic signed [HEAD_W-1:0] unit_comp(longint h, longint unsigned n);
    longint unsigned mag, q;
    mag = h < 0 ? -h : h;
    q = (mag * 32768 + n) / (2 * n);
    return HEAD_W'(h < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic pose_t playback_pose(logic [TIME_W-1:0] now);
    pose_t p;
    logic [TIME_W-1:0] date, d, den;
    int lo, hi, mid, i0, i1;
    longint lam;
    longint h [3];
    longint unsigned n, m;
    p = '{default: '0};
    if (trk_n == 0) begin
      pb_mode = REC_IDLE;
      return p;
    end
    date = now - pb_origin;
    lo = 0;
    hi = trk_n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (trk_time[mid] < date) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= trk_n) begin
      pb_mode = REC_IDLE;
      return sample_pose(trk_n - 1);
    end
    if (lo == 0 || !blend_on) return sample_pose(lo == 0 ? 0 : lo - 1);
    i0 = lo - 1;
    i1 = lo;
    d = date - trk_time[i0];
    den = trk_time[i1] - trk_time[i0];
    lam = den == 0 ? 0 : longint'((longint'(d) << 16) / longint'(den));
    p.vv = 1'b1;
    p.px = mix_pos(trk_px[i0], trk_px[i1], lam);
    p.py = mix_pos(trk_py[i0], trk_py[i1], lam);
    p.pz = mix_pos(trk_pz[i0], trk_pz[i1], lam);
    h[0] = lam * trk_hx[i1] + (65536 - lam) * trk_hx[i0];
    h[1] = lam * trk_hy[i1] + (65536 - lam) * trk_hy[i0];
    h[2] = lam * trk_hz[i1] + (65536 - lam) * trk_hz[i0];
    n = 0;
    for (int k = 0; k < 3; k++) begin
      m = h[k] < 0 ? -h[k] : h[k];
      n += m * m;
    end
    n = int_sqrt(n);
    if (n != 0) begin
      p.hx = unit_comp(h[0], n);
      p.hy = unit_comp(h[1], n);
      p.hz = unit_comp(h[2], n);
    end
    return p;
  endfunction

  function automatic pose_t predict_pose(tick_t t);
    pose_t p;
    logic [TIME_W-1:0] date;
    p = '{default: '0};
    case (t.mode)
      MODE_REC_TGL: begin
        if (pb_mode == REC_ON) begin
          pb_mode = REC_IDLE;
        end else begin
          pb_mode = REC_ON;
          pb_origin = t.now;
          trk_n = 0;
        end
      end
      MODE_PLAY_TGL: begin
        if (pb_mode == REC_PLAY) begin
          pb_mode = REC_IDLE;
        end else begin
          pb_mode = REC_PLAY;
          pb_origin = t.now;
        end
      end
      MODE_TICK: begin
        if (pb_mode == REC_ON) begin
          date = t.now - pb_origin;
          if (trk_n == 0 || date > trk_time[trk_n-1]) begin
            if (trk_n >= DEPTH) begin
              p.drop = 1'b1;
            end else begin
              trk_time[trk_n] = date;
              trk_px[trk_n] = t.px; trk_py[trk_n] = t.py; trk_pz[trk_n] = t.pz;
              trk_hx[trk_n] = t.hx; trk_hy[trk_n] = t.hy; trk_hz[trk_n] = t.hz;
              trk_n++;
            end
          end
        end else if (pb_mode == REC_PLAY) begin
          p = playback_pose(t.now);
        end
      end
      default: ;
    endcase
    p.rec = pb_mode == REC_ON;
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_valid && out_ready) begin
      if (poses_due.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        w = poses_due.pop_front();
        if (out_view_valid !== w.vv) report("view_valid", out_view_valid, w.vv);
        if (out_view_pos_x !== w.px) report("view_pos_x", out_view_pos_x, w.px);
        if (out_view_pos_y !== w.py) report("view_pos_y", out_view_pos_y, w.py);
        if (out_view_pos_z !== w.pz) report("view_pos_z", out_view_pos_z, w.pz);
        if (out_view_head_x !== w.hx) report("view_head_x", out_view_head_x, w.hx);
        if (out_view_head_y !== w.hy) report("view_head_y", out_view_head_y, w.hy);
        if (out_view_head_z !== w.hz) report("view_head_z", out_view_head_z, w.hz);
        if (out_is_recording !== w.rec) report("is_recording", out_is_recording, w.rec);
        if (out_sample_dropped !== w.drop)
          report("sample_dropped", out_sample_dropped, w.drop);
        n_poses += w.vv;
        n_drops += w.drop;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_camera_path_record_playback: FAIL");
      $finish;
    end
  end

  task automatic send(logic [1:0] mode, logic [TIME_W-1:0] now,
                      logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                      logic [HEAD_W-1:0] hx, logic [HEAD_W-1:0] hy,
                      logic [HEAD_W-1:0] hz);
    tick_t t;
    t = '{mode, now, px, py, pz, hx, hy, hz};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_now_ms <= now;
    in_cur_pos_x <= px; in_cur_pos_y <= py; in_cur_pos_z <= pz;
    in_cur_head_x <= hx; in_cur_head_y <= hy; in_cur_head_z <= hz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    poses_due.insert(poses_due.size(), predict_pose(t));
    n_items++;
  endtask

  task automatic send_rand(logic [1:0] mode, logic [TIME_W-1:0] now);
    send(mode, now, $urandom, $urandom, $urandom,
         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
         16'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (poses_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_blend(logic v);
    drain();
    repeat (5) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    blend_on = v;
  endtask

  task automatic test_directed();
    send_rand(MODE_UNUSED, 32'd5);
    send_rand(MODE_TICK, 32'd7);
    send_rand(MODE_PLAY_TGL, 32'd100);       // empty track
    send_rand(MODE_TICK, 32'd150);
    send_rand(MODE_REC_TGL, 32'd1000);
    send(MODE_TICK, 32'd1010, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
         16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_rand(MODE_TICK, 32'd1010);          // not newer, skipped
    send(MODE_TICK, 32'd1030, 32'h80000000, 32'h80000000, 32'h80000000,
         16'h8000, 16'h8000, 16'h8000);
    send(MODE_TICK, 32'd1050, 32'd0, 32'hFFFFFFFF, 32'd1, 16'd16384, 16'd0, 16'd0);
    send(MODE_TICK, 32'd1090, 32'd5, 32'd7, 32'd9, -16'sd16384, 16'd0, 16'd0);
    send_rand(MODE_PLAY_TGL, 32'd5000);      // playback straight from recording
    send_rand(MODE_TICK, 32'd5000);          // before first sample
    send_rand(MODE_TICK, 32'd5020);
    send_rand(MODE_TICK, 32'd5030);
    send_rand(MODE_TICK, 32'd5070);          // opposite headings cancel
    send_rand(MODE_TICK, 32'd5100);          // past the end
    send_rand(MODE_TICK, 32'd5110);
    set_blend(1'b0);
    send_rand(MODE_PLAY_TGL, 32'd0);
    send_rand(MODE_TICK, 32'd40);
    send_rand(MODE_PLAY_TGL, 32'd41);
    set_blend(1'b1);
    send_rand(MODE_REC_TGL, 32'hFFFFFFF0);
    send_rand(MODE_TICK, 32'h00000010);      // time wraps
    send_rand(MODE_REC_TGL, 32'h00000020);
  endtask

  task automatic test_full_store();
    logic [TIME_W-1:0] t0;
    t0 = $urandom;
    send_rand(MODE_REC_TGL, t0);
    for (int k = 0; k < DEPTH + 6; k++) send_rand(MODE_TICK, t0 + 3 * (k + 1));
    send_rand(MODE_PLAY_TGL, t0);
    for (int k = 0; k < 4; k++) send_rand(MODE_TICK, t0 + $urandom_range(0, 3 * DEPTH));
    send_rand(MODE_TICK, t0 + 3 * DEPTH + 10);
  endtask

  task automatic test_random(int count, logic pressure);
    logic [TIME_W-1:0] t, span;
    int stop;
    stop = n_items + count;
    while (n_items < stop) begin
      if (pressure && n_items > stop - count / 2) begin
        drain();
        pressure = 1'b0;
      end
      if ($urandom_range(9) == 0) begin
        send_rand(2'($urandom_range(0, 3)), $urandom);
        continue;
      end
      t = $urandom_range(2) == 0 ? 32'hFFFFFF00 + $urandom_range(0, 255) : $urandom;
      send_rand(MODE_REC_TGL, t);
      span = 0;
      repeat ($urandom_range(1, 12)) begin
        span += $urandom_range(7) == 0 ? 0 : $urandom_range(1, 200);
        send_rand(MODE_TICK, t + span);
      end
      if ($urandom_range(1)) send_rand(MODE_REC_TGL, t + span);
      t = $urandom;
      send_rand(MODE_PLAY_TGL, t);
      repeat ($urandom_range(1, 10)) begin
        if (pb_mode != REC_PLAY) break;
        send_rand(MODE_TICK, t + ($urandom_range(5) == 0 ? $urandom
                                  : $urandom_range(0, span + 50)));
      end
      if (pb_mode == REC_PLAY) send_rand(MODE_PLAY_TGL, t);
      else if (pb_mode == REC_ON) send_rand(MODE_REC_TGL, t);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 54;
    test_directed();
    test_full_store();
    test_random(220, 1'b0);
    set_blend(1'b0);
    send_idle_pct = 54;
    recv_idle_pct = 9;
    test_random(220, 1'b0);
    set_blend(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220, 1'b1);
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: %0d played poses, %0d dropped samples,",
             n_items, n_poses, n_drops);
    $display("full store, blend on and off, wrapping time and three idling mixes");
    if (n_errors == 0 && poses_due.size() == 0) begin
      $display("tb_camera_path_record_playback: PASS");
    end else begin
      $display("tb_camera_path_record_playback: FAIL");
    end
    $finish;
  end

endmodule
